### rtl/beacon_rssi_tracker_macros.svh
// Assertion macros for the tracker's RTL file.
`ifndef BEACON_RSSI_TRACKER_MACROS_SVH
`define BEACON_RSSI_TRACKER_MACROS_SVH

// Same-cycle implication, checked on the rising edge of clk outside reset.
`define BRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on the rising edge of clk outside reset.
`define BRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/brt_pkg.sv
// Package: item types, register indexes and constants of the beacon RSSI tracker.
`default_nettype none

package brt_pkg;

  localparam int MAX_TARGETS = 6;
  localparam int SLOT_W      = 3;
  localparam int ADDR_W      = 48;
  localparam int TIME_W      = 32;
  localparam int AVG_W       = 16;
  localparam int CFG_IDX_W   = 3;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_PUB_INTERVAL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COUNT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ADDR0 = 3'd2;

  // Register reset values
  localparam logic [15:0]       PUB_INTERVAL_RST = 16'd100;
  localparam logic [2:0]        TARGET_COUNT_RST = 3'd1;
  localparam logic [ADDR_W-1:0] TARGET_ADDR0_RST = 48'hDD88_0000_1307;

  // EMA weights in 1/256: 77 for the sample, 179 for the old average
  localparam logic signed [7:0] W_SAMPLE = 8'sd77;
  localparam logic signed [8:0] W_AVG    = 9'sd179;

  typedef struct packed {
    logic [ADDR_W-1:0]  beacon_addr;
    logic signed [7:0]  rssi_dbm;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic                    matched;
    logic [SLOT_W-1:0]       slot_index;
    logic                    publish;
    logic signed [7:0]       rssi_raw;
    logic signed [AVG_W-1:0] rssi_avg_q8;
  } out_item_t;

endpackage

`default_nettype wire

### rtl/beacon_rssi_tracker.sv
// Beacon RSSI tracker: per-slot EMA of RSSI with publish gating, state in a slot memory.
// Steps: an accepted item passes match, read, multiply, then update into the output register,
//   where its result becomes valid.
// Flow: no new item is accepted until the read-modify-write pass over the slot memory ends;
//   a pass waits in its update step while a previous result is still stalled.
// Reset: rst_n (synchronous) restores register defaults and clears the per-slot valid bits;
//   an invalid slot reads as zero average and zero publish time, so no clearing pass runs.
`default_nettype none

`include "beacon_rssi_tracker_macros.svh"

module beacon_rssi_tracker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire brt_pkg::in_item_t              in_item,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output brt_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_we,
  input  wire logic [brt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [brt_pkg::ADDR_W-1:0]     cfg_wdata
);
  import brt_pkg::*;

  localparam int MEM_W = AVG_W + TIME_W;

  // Sequencer codes
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MATCH = 3'd1;
  localparam logic [2:0] S_READ  = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_UPD   = 3'd4;

  // Configuration registers
  logic [15:0]       interval_r;
  logic [2:0]        count_r;
  logic [ADDR_W-1:0] tgt_r [MAX_TARGETS];

  // Sequencer and item context
  logic [2:0]        st_r, st_nxt;
  in_item_t          item_r;
  logic              matched_r;
  logic [SLOT_W-1:0] slot_r;

  // Slot memory: {average, last publish time}; valid bits live in flops
  logic [MEM_W-1:0]       mem_r [MAX_TARGETS];
  logic [MEM_W-1:0]       rdata_r;
  logic                   rvalid_r;
  logic [MAX_TARGETS-1:0] vld_r;

  // Datapath registers
  logic signed [15:0]      ps_r;   // 77 * rssi, still to be scaled by 256
  logic signed [24:0]      pa_r;   // 179 * old average
  logic                    seed_r;
  logic                    pub_r;
  logic [TIME_W-1:0]       last_r;

  out_item_t out_r;
  logic      out_valid_r;

  logic                    commit;
  logic [2:0]              active;
  logic                    hit;
  logic [SLOT_W-1:0]       hit_slot;
  logic signed [AVG_W-1:0] avg_cur;
  logic [TIME_W-1:0]       last_cur;
  logic signed [24:0]      sum;
  logic signed [16:0]      quot;
  logic signed [AVG_W-1:0] avg_new;

  assign in_stall  = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // Finish the pass once the output register is free or being emptied
  assign commit = (st_r == S_UPD) && (!out_valid_r || !out_stall);

  // Clamp the slot count, then take the lowest matching active slot
  always_comb begin
    active   = (count_r > 3'(MAX_TARGETS)) ? 3'(MAX_TARGETS) : count_r;
    hit      = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < MAX_TARGETS; i++) begin
      if (!hit && (3'(i) < active) && (tgt_r[i] == item_r.beacon_addr)) begin
        hit      = 1'b1;
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // Invalid entries read as zero
  assign avg_cur  = rvalid_r ? $signed(rdata_r[MEM_W-1:TIME_W]) : '0;
  assign last_cur = rvalid_r ? rdata_r[TIME_W-1:0] : '0;

  // Sum, floor-divide by 256, saturate to Q8.8; on an invalid slot the sample seeds the average
  always_comb begin
    sum  = 25'($signed({ps_r, 8'h00})) + pa_r;
    quot = sum[24:8];
    if (quot[16] != quot[15]) begin
      avg_new = quot[16] ? 16'sh8000 : 16'sh7FFF;
    end else begin
      avg_new = quot[15:0];
    end
    if (seed_r) begin
      avg_new = {item_r.rssi_dbm, 8'h00};
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE:  if (in_valid) st_nxt = S_MATCH;
      S_MATCH: st_nxt = S_READ;
      S_READ:  st_nxt = S_CALC;
      S_CALC:  st_nxt = S_UPD;
      S_UPD:   if (commit) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // Control state and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      interval_r  <= PUB_INTERVAL_RST;
      count_r     <= TARGET_COUNT_RST;
      for (int i = 0; i < MAX_TARGETS; i++) begin
        tgt_r[i] <= (i == 0) ? TARGET_ADDR0_RST : '0;
      end
    end else begin
      st_r <= st_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (commit && matched_r) begin
        vld_r[slot_r] <= 1'b1;
      end
      if (cfg_we) begin
        if (cfg_index == REG_PUB_INTERVAL) begin
          interval_r <= cfg_wdata[15:0];
        end else if (cfg_index == REG_TARGET_COUNT) begin
          count_r <= cfg_wdata[2:0];
        end else begin
          for (int i = 0; i < MAX_TARGETS; i++) begin
            if (cfg_index == REG_TARGET_ADDR0 + CFG_IDX_W'(i)) begin
              tgt_r[i] <= cfg_wdata;
            end
          end
        end
      end
    end
  end

  // Slot memory: registered read, write at the end of the pass
  always_ff @(posedge clk) begin
    if (st_r == S_READ) begin
      rdata_r  <= mem_r[slot_r];
      rvalid_r <= vld_r[slot_r];
    end
    if (commit && matched_r) begin
      mem_r[slot_r] <= {avg_new, pub_r ? item_r.now_ms : last_r};
    end
  end

  // Payload and datapath
  always_ff @(posedge clk) begin
    if ((st_r == S_IDLE) && in_valid) begin
      item_r <= in_item;
    end
    if (st_r == S_MATCH) begin
      matched_r <= hit;
      slot_r    <= hit_slot;
    end
    if (st_r == S_CALC) begin
      ps_r   <= 16'(W_SAMPLE) * 16'($signed(item_r.rssi_dbm));
      pa_r   <= 25'(W_AVG) * 25'(avg_cur);
      seed_r <= !rvalid_r;
      last_r <= last_cur;
      pub_r  <= (item_r.now_ms - last_cur) >= {16'h0000, interval_r};
    end
    if (commit) begin
      out_r.matched     <= matched_r;
      out_r.slot_index  <= matched_r ? slot_r : '0;
      out_r.publish     <= matched_r && pub_r;
      out_r.rssi_raw    <= item_r.rssi_dbm;
      out_r.rssi_avg_q8 <= matched_r ? avg_new : '0;
    end
  end

  // Checks
  `BRT_ASSERT_NEXT(a_accept_starts_pass, (in_valid && !in_stall), (st_r == S_MATCH), "accept did not start a pass")
  `BRT_ASSERT_NOW(a_nomatch_quiet, (out_valid && !out_item.matched), (!out_item.publish && out_item.slot_index == '0 && out_item.rssi_avg_q8 == '0), "unmatched result carries slot data")
  `BRT_ASSERT_NEXT(a_commit_sets_valid, (commit && matched_r), (vld_r[slot_r] && out_valid), "matched pass left slot invalid")

endmodule

`default_nettype wire
